// File: rtl/core/lnkc_pkg.sv
// lnkc_pkg: shared types, command codes and default sizes for the lru key cache
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lnkc_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned CFG_W = 5;

  localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // writes and reads towards the entry store
  typedef struct packed {
    logic rd_en;
    logic rank_we;
    logic key_we;
    logic valid_set;
    logic valid_clr;
    logic flush_all;
  } lnkc_mem_ctl_t;

  // tag on the registered read data
  typedef struct packed {
    logic vld;
    logic entry_valid;
  } lnkc_mem_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/lru_negative_key_cache_top.sv
// Fully associative key set with least-recently-used replacement. A command is
// taken when start is high and busy is low; the result is shown for exactly one
// cycle with result_valid_o and cannot be held off, so the receiver must take it
// then. A query or an add scans the entry store one entry a cycle through a
// single memory read port; a query hit or an add of a new key then makes a
// second rank pass. A query miss or an add hit returns after the scan and a
// decide step, a query hit after the rank pass, an add of a new key after the
// rank pass and an insert step; flush and the unused command answer in the
// cycle after the transfer. The capacity limit (cfg_data_i) is written only
// while busy is low; zero acts as one and values above CAPACITY act as CAPACITY.
// depends on lnkc_pkg, lnkc_entry_mem and lnkc_seq
`timescale 1ns / 1ps
`default_nettype none

module lru_negative_key_cache_top
  import lnkc_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [KEY_BITS-1:0] key_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  output logic                     result_valid_o,
  output logic                     hit_o,
  output logic                     evicted_o,
  output logic [KEY_BITS-1:0]      evicted_key_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned RANK_W = $clog2(CAPACITY);

  lnkc_mem_ctl_t       mem_ctl;
  lnkc_mem_rsp_t       mem_rsp;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [RANK_W-1:0]   rank_wdata;
  logic [KEY_BITS-1:0] key_wdata;
  logic [IDX_W-1:0]    rsp_addr;
  logic [KEY_BITS-1:0] rsp_key;
  logic [RANK_W-1:0]   rsp_rank;

  lnkc_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W),
    .RANK_W   (RANK_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .key_i          (key_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .ctl_o          (mem_ctl),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .rank_wdata_o   (rank_wdata),
    .key_wdata_o    (key_wdata),
    .rsp_i          (mem_rsp),
    .rsp_addr_i     (rsp_addr),
    .rsp_key_i      (rsp_key),
    .rsp_rank_i     (rsp_rank)
  );

  lnkc_entry_mem #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W),
    .RANK_W   (RANK_W)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mem_ctl),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .rank_wdata_i (rank_wdata),
    .key_wdata_i  (key_wdata),
    .rsp_o        (mem_rsp),
    .rsp_addr_o   (rsp_addr),
    .rsp_key_o    (rsp_key),
    .rsp_rank_o   (rsp_rank)
  );

endmodule

`default_nettype wire

// File: rtl/core/lnkc_entry_mem.sv
// lnkc_entry_mem: key and rank memories with per-entry valid flops
// one read port with registered data, one write port; uses lnkc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lnkc_entry_mem
  import lnkc_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned RANK_W   = $clog2(CAPACITY)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lnkc_mem_ctl_t       ctl_i,
  input  wire logic [IDX_W-1:0]    rd_addr_i,
  input  wire logic [IDX_W-1:0]    wr_addr_i,
  input  wire logic [RANK_W-1:0]   rank_wdata_i,
  input  wire logic [KEY_BITS-1:0] key_wdata_i,
  output lnkc_mem_rsp_t            rsp_o,
  output logic [IDX_W-1:0]         rsp_addr_o,
  output logic [KEY_BITS-1:0]      rsp_key_o,
  output logic [RANK_W-1:0]        rsp_rank_o
);

  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [RANK_W-1:0]   rank_mem [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  lnkc_mem_rsp_t       rsp_q;
  logic [IDX_W-1:0]    rsp_addr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[wr_addr_i] <= key_wdata_i;
    end
    if (ctl_i.rank_we) begin
      rank_mem[wr_addr_i] <= rank_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rsp_key_o  <= key_mem[rd_addr_i];
      rsp_rank_o <= rank_mem[rd_addr_i];
      rsp_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rsp_q   <= '0;
    end else begin
      rsp_q.vld <= ctl_i.rd_en;
      if (ctl_i.rd_en) begin
        rsp_q.entry_valid <= valid_q[rd_addr_i];
      end
      if (ctl_i.flush_all) begin
        valid_q <= '0;
      end else if (ctl_i.valid_set) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.valid_clr) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  assign rsp_o      = rsp_q;
  assign rsp_addr_o = rsp_addr_q;

endmodule

`default_nettype wire

// File: rtl/core/lnkc_seq.sv
// lnkc_seq: sequencer with the shared key and rank compare unit
// scans the entry store one entry a cycle; uses lnkc_pkg and lnkc_entry_mem ports
`timescale 1ns / 1ps
`default_nettype none

module lnkc_seq
  import lnkc_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned RANK_W   = $clog2(CAPACITY)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [KEY_BITS-1:0] key_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  output logic                     result_valid_o,
  output logic                     hit_o,
  output logic                     evicted_o,
  output logic [KEY_BITS-1:0]      evicted_key_o,
  output lnkc_mem_ctl_t            ctl_o,
  output logic [IDX_W-1:0]         rd_addr_o,
  output logic [IDX_W-1:0]         wr_addr_o,
  output logic [RANK_W-1:0]        rank_wdata_o,
  output logic [KEY_BITS-1:0]      key_wdata_o,
  input  wire lnkc_mem_rsp_t       rsp_i,
  input  wire logic [IDX_W-1:0]    rsp_addr_i,
  input  wire logic [KEY_BITS-1:0] rsp_key_i,
  input  wire logic [RANK_W-1:0]   rsp_rank_i
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [LIM_W-1:0] CAP_LIM  = LIM_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPD    = 3'd3;
  localparam logic [2:0] ST_INS    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic                iss_q, iss_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CFG_W-1:0]    cfg_q, cfg_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    hit_slot_q, hit_slot_d;
  logic [RANK_W-1:0]   hit_rank_q, hit_rank_d;
  logic [IDX_W-1:0]    lru_slot_q, lru_slot_d;
  logic [KEY_BITS-1:0] lru_key_q, lru_key_d;
  logic                free_found_q, free_found_d;
  logic [IDX_W-1:0]    free_slot_q, free_slot_d;
  logic                evict_q, evict_d;
  logic [IDX_W-1:0]    ins_slot_q, ins_slot_d;
  logic                res_vld_q, res_vld_d;
  logic                res_hit_q, res_hit_d;
  logic                res_evicted_q, res_evicted_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;

  logic [LIM_W-1:0] cfg_ext, cnt_ext, eff_lim;
  logic             evict_need;
  logic             last_rsp;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = ~busy;

  // effective limit: zero acts as one, clamped to the store size
  assign cfg_ext    = LIM_W'(cfg_q);
  assign cnt_ext    = LIM_W'(count_q);
  assign eff_lim    = (cfg_ext == '0) ? LIM_W'(1) : ((cfg_ext > CAP_LIM) ? CAP_LIM : cfg_ext);
  assign evict_need = (cnt_ext >= eff_lim);
  assign last_rsp   = rsp_i.vld && (rsp_addr_i == LAST_IDX);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    iss_d         = iss_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    cfg_d         = cfg_q;
    count_d       = count_q;
    found_d       = found_q;
    hit_slot_d    = hit_slot_q;
    hit_rank_d    = hit_rank_q;
    lru_slot_d    = lru_slot_q;
    lru_key_d     = lru_key_q;
    free_found_d  = free_found_q;
    free_slot_d   = free_slot_q;
    evict_d       = evict_q;
    ins_slot_d    = ins_slot_q;
    res_vld_d     = 1'b0;
    res_hit_d     = res_hit_q;
    res_evicted_d = res_evicted_q;
    res_key_d     = res_key_q;
    ctl_o         = '0;
    rd_addr_o     = cnt_q;
    wr_addr_o     = ins_slot_q;
    rank_wdata_o  = '0;
    key_wdata_o   = key_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    // read issue for both passes
    if (iss_q && (state_q == ST_SCAN || state_q == ST_UPD)) begin
      ctl_o.rd_en = 1'b1;
      if (cnt_q == LAST_IDX) begin
        iss_d = 1'b0;
      end else begin
        cnt_d = cnt_q + IDX_W'(1);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (command_i)
            CMD_QUERY, CMD_ADD: begin
              cmd_d        = command_i;
              key_d        = key_i;
              cnt_d        = '0;
              iss_d        = 1'b1;
              found_d      = 1'b0;
              free_found_d = 1'b0;
              state_d      = ST_SCAN;
            end
            CMD_FLUSH: begin
              ctl_o.flush_all = 1'b1;
              count_d         = '0;
              res_vld_d       = 1'b1;
              res_hit_d       = 1'b0;
              res_evicted_d   = 1'b0;
              res_key_d       = '0;
            end
            default: begin
              res_vld_d     = 1'b1;
              res_hit_d     = 1'b0;
              res_evicted_d = 1'b0;
              res_key_d     = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rsp_i.vld) begin
          if (rsp_i.entry_valid && (rsp_key_i == key_q)) begin
            found_d    = 1'b1;
            hit_slot_d = rsp_addr_i;
            hit_rank_d = rsp_rank_i;
          end
          if (rsp_i.entry_valid && (CNT_W'(rsp_rank_i) == count_q - CNT_W'(1))) begin
            lru_slot_d = rsp_addr_i;
            lru_key_d  = rsp_key_i;
          end
          if (!rsp_i.entry_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = rsp_addr_i;
          end
        end
        if (last_rsp) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (cmd_q == CMD_ADD) begin
          if (found_q) begin
            res_vld_d     = 1'b1;
            res_hit_d     = 1'b1;
            res_evicted_d = 1'b0;
            res_key_d     = '0;
            state_d       = ST_IDLE;
          end else begin
            evict_d = evict_need;
            if (evict_need) begin
              ctl_o.valid_clr = 1'b1;
              wr_addr_o       = lru_slot_q;
            end
            // lowest free index once the lru entry is gone
            if (evict_need && (!free_found_q || (lru_slot_q < free_slot_q))) begin
              ins_slot_d = lru_slot_q;
            end else begin
              ins_slot_d = free_slot_q;
            end
            cnt_d   = '0;
            iss_d   = 1'b1;
            state_d = ST_UPD;
          end
        end else if (found_q) begin
          cnt_d   = '0;
          iss_d   = 1'b1;
          state_d = ST_UPD;
        end else begin
          res_vld_d     = 1'b1;
          res_hit_d     = 1'b0;
          res_evicted_d = 1'b0;
          res_key_d     = '0;
          state_d       = ST_IDLE;
        end
      end

      ST_UPD: begin
        if (rsp_i.vld) begin
          wr_addr_o = rsp_addr_i;
          if (cmd_q == CMD_ADD) begin
            if (rsp_i.entry_valid) begin
              ctl_o.rank_we = 1'b1;
              rank_wdata_o  = rsp_rank_i + RANK_W'(1);
            end
          end else if (rsp_addr_i == hit_slot_q) begin
            ctl_o.rank_we = 1'b1;
            rank_wdata_o  = '0;
          end else if (rsp_i.entry_valid && (rsp_rank_i < hit_rank_q)) begin
            ctl_o.rank_we = 1'b1;
            rank_wdata_o  = rsp_rank_i + RANK_W'(1);
          end
        end
        if (last_rsp) begin
          if (cmd_q == CMD_ADD) begin
            state_d = ST_INS;
          end else begin
            res_vld_d     = 1'b1;
            res_hit_d     = 1'b1;
            res_evicted_d = 1'b0;
            res_key_d     = '0;
            state_d       = ST_IDLE;
          end
        end
      end

      ST_INS: begin
        ctl_o.key_we    = 1'b1;
        ctl_o.rank_we   = 1'b1;
        ctl_o.valid_set = 1'b1;
        wr_addr_o       = ins_slot_q;
        rank_wdata_o    = '0;
        if (!evict_q) begin
          count_d = count_q + CNT_W'(1);
        end
        res_vld_d     = 1'b1;
        res_hit_d     = 1'b0;
        res_evicted_d = evict_q;
        res_key_d     = evict_q ? lru_key_q : '0;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_q     <= 1'b0;
      cfg_q     <= CFG_LIMIT_RESET;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      cfg_q     <= cfg_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q         <= cnt_d;
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    found_q       <= found_d;
    hit_slot_q    <= hit_slot_d;
    hit_rank_q    <= hit_rank_d;
    lru_slot_q    <= lru_slot_d;
    lru_key_q     <= lru_key_d;
    free_found_q  <= free_found_d;
    free_slot_q   <= free_slot_d;
    evict_q       <= evict_d;
    ins_slot_q    <= ins_slot_d;
    res_hit_q     <= res_hit_d;
    res_evicted_q <= res_evicted_d;
    res_key_q     <= res_key_d;
  end

  assign result_valid_o = res_vld_q;
  assign hit_o          = res_hit_q;
  assign evicted_o      = res_evicted_q;
  assign evicted_key_o  = res_key_q;

endmodule

`default_nettype wire
